### src/bof_pkg.sv
// Shared widths, codes and types of the Bezier outline flattener.
package bof_pkg;

  // Fixed field widths of the command and point channels.
  localparam int COORD_W  = 24;
  localparam int OFFSET_W = 32;
  localparam int POINT_W  = 32;
  localparam int STEPS_W  = 7;

  // Register port: one 32-bit register per word.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register indexes and reset values.
  localparam logic [0:0]         REG_STEPS   = 1'b0;
  localparam logic [STEPS_W-1:0] STEPS_RESET = 7'd1;

  // Outline command codes.
  typedef enum logic [1:0] {
    OP_MOVE  = 2'd0,
    OP_LINE  = 2'd1,
    OP_QUAD  = 2'd2,
    OP_CUBIC = 2'd3
  } op_t;

  // Status of the iterative divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### src/bof_mac.sv
// Shared multiply-accumulate unit: signed operand times unsigned weight plus accumulator.
module bof_mac #(
  parameter int AW = 33,
  parameter int MW = 21,
  parameter int RW = 56
) (
  input  logic                 clr,
  input  logic signed [AW-1:0] a,
  input  logic        [MW-1:0] mul,
  input  logic signed [RW-1:0] acc,
  output logic signed [RW-1:0] res
);

  logic signed [AW+MW:0] prod;

  // The weight is always non-negative, so it enters the product zero-extended.
  assign prod = a * $signed({1'b0, mul});

  // Start a new sum or add onto the running one.
  assign res = (clr ? '0 : acc) + {{(RW-AW-MW-1){prod[AW+MW]}}, prod};

endmodule

### src/bof_div.sv
// Iterative signed divider that rounds to nearest, ties away from zero, one quotient bit per cycle.
module bof_div #(
  parameter int NW = 56,
  parameter int WW = 21,
  parameter int QW = 33
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [NW-1:0]   num,
  input  logic        [WW-1:0]   den,
  output bof_pkg::div_stat_t     stat,
  output logic signed [QW:0]     quot
);

  localparam int CW = $clog2(QW);

  typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN} dstate_t;

  dstate_t         dstate;
  logic [CW-1:0]   cnt;
  logic            neg;
  logic            done;
  logic [NW-1:0]   rem;
  logic [NW-1:0]   dsh;
  logic [QW-1:0]   q;
  logic [NW:0]     diff;
  logic [NW-1:0]   half;
  logic [QW:0]     q_ext;

  // Half the divisor, added to the magnitude for round to nearest.
  assign half = {{(NW-WW+1){1'b0}}, den[WW-1:1]};

  // Trial subtraction of the shifted divisor.
  assign diff = {1'b0, rem} - {1'b0, dsh};

  // Sequencer of the divider: load, take magnitude and round, then one bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (dstate)
        D_IDLE: begin
          if (start) begin
            neg    <= num[NW-1];
            rem    <= num;
            dsh    <= {{(NW-WW-QW+1){1'b0}}, den, {(QW-1){1'b0}}};
            dstate <= D_PREP;
          end
        end
        D_PREP: begin
          rem    <= neg ? (~rem + half + NW'(1)) : (rem + half);
          cnt    <= CW'(QW - 1);
          q      <= '0;
          dstate <= D_RUN;
        end
        D_RUN: begin
          if (!diff[NW]) begin
            rem <= diff[NW-1:0];
            q   <= {q[QW-2:0], 1'b1};
          end else begin
            q   <= {q[QW-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          if (cnt == '0) begin
            done   <= 1'b1;
            dstate <= D_IDLE;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

  // Restore the sign of the rounded quotient.
  assign q_ext = {1'b0, q};
  assign quot  = neg ? -$signed(q_ext) : $signed(q_ext);

  assign stat.busy = (dstate != D_IDLE);
  assign stat.done = done;

endmodule

### src/bezier_outline_flattener_top.sv
// Bezier outline flattener: turns move, line and curve commands into Q.FRAC_BITS points.
// Move and line: the request is captured, then the point is registered in the push state once
// the output register is free; a new request is taken only after the point is pushed. Curves run
// the denominator, weight, numerator and division steps on PW = max(24+FRAC_BITS, 32)+1 bit wide
// values on the shared multiply-accumulate unit and the divider, one quotient bit per cycle.
// Synchronous reset clears the current point to (0,0), steps to 1 and empties the output register.
module bezier_outline_flattener_top #(
  parameter int MAX_STEPS = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bof_pkg::ADDR_W-1:0]            paddr,
  input  logic [bof_pkg::DATA_W-1:0]            pwdata,
  output logic [bof_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready,
  // Command channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            op,
  input  logic signed [bof_pkg::COORD_W-1:0]    ctrl1_x,
  input  logic signed [bof_pkg::COORD_W-1:0]    ctrl1_y,
  input  logic signed [bof_pkg::COORD_W-1:0]    ctrl2_x,
  input  logic signed [bof_pkg::COORD_W-1:0]    ctrl2_y,
  input  logic signed [bof_pkg::COORD_W-1:0]    end_x,
  input  logic signed [bof_pkg::COORD_W-1:0]    end_y,
  input  logic signed [bof_pkg::OFFSET_W-1:0]   offset_x,
  input  logic signed [bof_pkg::OFFSET_W-1:0]   offset_y,
  // Point channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [bof_pkg::POINT_W-1:0]    point_x,
  output logic signed [bof_pkg::POINT_W-1:0]    point_y,
  output logic                                  starts_contour,
  output logic                                  last
);

  localparam int CRD_W = bof_pkg::COORD_W;
  localparam int OFF_W = bof_pkg::OFFSET_W;
  localparam int PT_W  = bof_pkg::POINT_W;
  localparam int STW   = bof_pkg::STEPS_W;
  localparam int DW    = bof_pkg::DATA_W;
  localparam int AW    = bof_pkg::ADDR_W;

  // Step count, weight, point, numerator and quotient widths.
  localparam int SW = $clog2(MAX_STEPS + 1);
  localparam int WW = 3 * SW;
  localparam int PW = ((CRD_W + FRAC_BITS > PT_W) ? (CRD_W + FRAC_BITS) : PT_W) + 1;
  localparam int NW = PW + WW + 2;
  localparam int QW = PW;

  localparam logic signed [PW:0] SAT_HI = {{(PW+2-PT_W){1'b0}}, {(PT_W-1){1'b1}}};
  localparam logic signed [PW:0] SAT_LO = {{(PW+2-PT_W){1'b1}}, {(PT_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_DEN, S_WGT, S_MACX, S_DIVX, S_MACY, S_DIVY, S_PUSH
  } state_t;

  state_t                 state;
  logic [2:0]             ustep;
  bof_pkg::op_t           op_q;
  logic [STW-1:0]         steps;
  logic signed [PT_W-1:0] current_x;
  logic signed [PT_W-1:0] current_y;
  logic [SW-1:0]          n;
  logic [SW-1:0]          n_in;
  logic [SW-1:0]          k;
  logic [SW-1:0]          mk;
  logic [WW-1:0]          den;
  logic [WW-1:0]          t1;
  logic [WW-1:0]          t2;
  logic [WW-1:0]          u;
  logic [WW-1:0]          w0;
  logic [WW-1:0]          w1;
  logic [WW-1:0]          w2;
  logic [WW-1:0]          w3;
  logic [WW-1:0]          wres;
  logic signed [PW-1:0]   p0x;
  logic signed [PW-1:0]   p0y;
  logic signed [PW-1:0]   c1x;
  logic signed [PW-1:0]   c1y;
  logic signed [PW-1:0]   c2x;
  logic signed [PW-1:0]   c2y;
  logic signed [PW-1:0]   ex;
  logic signed [PW-1:0]   ey;
  logic signed [PW-1:0]   ex_in;
  logic signed [PW-1:0]   ey_in;
  logic signed [PW:0]     qx;
  logic signed [PW:0]     qy;
  logic signed [PT_W-1:0] sat_x;
  logic signed [PT_W-1:0] sat_y;
  logic signed [NW-1:0]   acc;
  logic signed [NW-1:0]   mac_res;
  logic signed [PW-1:0]   mac_a;
  logic [WW-1:0]          mac_mul;
  logic                   mac_clr;
  logic                   div_start;
  logic signed [PW:0]     div_quot;
  bof_pkg::div_stat_t     div_stat;
  logic                   out_free;
  logic                   pt_last;
  logic                   is_cubic;

  // Font units to Q.FRAC_BITS with the glyph offset added.
  function automatic logic signed [PW-1:0] to_fixed(input logic signed [CRD_W-1:0] uv,
                                                    input logic signed [OFF_W-1:0] ov);
    logic signed [PW-1:0] us;
    logic signed [PW-1:0] os;
    us = {{(PW-CRD_W){uv[CRD_W-1]}}, uv};
    os = {{(PW-OFF_W){ov[OFF_W-1]}}, ov};
    return (us <<< FRAC_BITS) + os;
  endfunction

  // Clamp a wide point coordinate to the signed output range.
  function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [PW:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[PT_W-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[PT_W-1:0];
    end
    return v[PT_W-1:0];
  endfunction

  // Zero-extension helpers for the operands of the shared unit.
  function automatic logic signed [PW-1:0] zs(input logic [SW-1:0] v);
    return {{(PW-SW){1'b0}}, v};
  endfunction

  function automatic logic signed [PW-1:0] zw(input logic [WW-1:0] v);
    return {{(PW-WW){1'b0}}, v};
  endfunction

  function automatic logic [WW-1:0] ms(input logic [SW-1:0] v);
    return {{(WW-SW){1'b0}}, v};
  endfunction

  // Register port: steps is the only register.
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= bof_pkg::STEPS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[AW-1:2] == bof_pkg::REG_STEPS)) begin
      steps <= pwdata[STW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[AW-1:2] == bof_pkg::REG_STEPS) ? DW'(steps) : '0;

  // Effective step count: zero counts as one, large values clamp to the maximum.
  always_comb begin
    if (steps == '0) begin
      n_in = SW'(1);
    end else if (steps > STW'(MAX_STEPS)) begin
      n_in = SW'(MAX_STEPS);
    end else begin
      n_in = steps[SW-1:0];
    end
  end

  assign ex_in    = to_fixed(end_x, offset_x);
  assign ey_in    = to_fixed(end_y, offset_y);
  assign mk       = n - k;
  assign wres     = mac_res[WW-1:0];
  assign is_cubic = (op_q == bof_pkg::OP_CUBIC);
  assign pt_last  = (op_q == bof_pkg::OP_MOVE) || (op_q == bof_pkg::OP_LINE) || (k == n);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign sat_x    = sat_pt(qx);
  assign sat_y    = sat_pt(qy);

  // Operand selection for the shared multiply-accumulate unit.
  always_comb begin
    mac_a   = '0;
    mac_mul = '0;
    mac_clr = 1'b1;
    unique case (state)
      S_DEN: begin
        if (ustep == 3'd0) begin
          mac_a   = zs(n);
          mac_mul = ms(n);
        end else begin
          mac_a   = zw(den);
          mac_mul = ms(n);
        end
      end
      S_WGT: begin
        if (is_cubic) begin
          case (ustep)
            3'd0:    begin mac_a = zs(mk); mac_mul = ms(mk);   end
            3'd1:    begin mac_a = zw(t1); mac_mul = ms(mk);   end
            3'd2:    begin mac_a = zs(k);  mac_mul = ms(k);    end
            3'd3:    begin mac_a = zw(t2); mac_mul = ms(k);    end
            3'd4:    begin mac_a = zw(t1); mac_mul = ms(k);    end
            3'd5:    begin mac_a = zw(u);  mac_mul = WW'(3);   end
            3'd6:    begin mac_a = zw(t2); mac_mul = ms(mk);   end
            default: begin mac_a = zw(u);  mac_mul = WW'(3);   end
          endcase
        end else begin
          case (ustep)
            3'd0:    begin mac_a = zs(mk); mac_mul = ms(mk);   end
            3'd1:    begin mac_a = zs(k);  mac_mul = ms(k);    end
            3'd2:    begin mac_a = zs(k);  mac_mul = ms(mk);   end
            default: begin mac_a = zw(u);  mac_mul = WW'(2);   end
          endcase
        end
      end
      S_MACX: begin
        mac_clr = (ustep == 3'd0);
        case (ustep)
          3'd0:    begin mac_a = p0x; mac_mul = w0; end
          3'd1:    begin mac_a = c1x; mac_mul = w1; end
          3'd2:    begin mac_a = c2x; mac_mul = w2; end
          default: begin mac_a = ex;  mac_mul = w3; end
        endcase
      end
      S_MACY: begin
        mac_clr = (ustep == 3'd0);
        case (ustep)
          3'd0:    begin mac_a = p0y; mac_mul = w0; end
          3'd1:    begin mac_a = c1y; mac_mul = w1; end
          3'd2:    begin mac_a = c2y; mac_mul = w2; end
          default: begin mac_a = ey;  mac_mul = w3; end
        endcase
      end
      default: begin
        mac_a   = '0;
        mac_mul = '0;
      end
    endcase
  end

  // The divider takes the finished numerator straight from the last accumulate.
  assign div_start = ((state == S_MACX) || (state == S_MACY)) && (ustep == 3'd3);

  bof_mac #(
    .AW (PW),
    .MW (WW),
    .RW (NW)
  ) u_mac (
    .clr (mac_clr),
    .a   (mac_a),
    .mul (mac_mul),
    .acc (acc),
    .res (mac_res)
  );

  bof_div #(
    .NW (NW),
    .WW (WW),
    .QW (QW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mac_res),
    .den   (den),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // Main sequencer: capture, then for curves denominator, weights, numerators and divisions, then push.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ustep     <= '0;
      out_valid <= 1'b0;
      current_x <= '0;
      current_y <= '0;
    end else begin
      // A taken point leaves the register unless a new one is loaded in the same cycle.
      if (out_valid && out_ready && (state != S_PUSH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= bof_pkg::op_t'(op);
            ex    <= ex_in;
            ey    <= ey_in;
            c1x   <= to_fixed(ctrl1_x, offset_x);
            c1y   <= to_fixed(ctrl1_y, offset_y);
            c2x   <= to_fixed(ctrl2_x, offset_x);
            c2y   <= to_fixed(ctrl2_y, offset_y);
            p0x   <= {{(PW-PT_W){current_x[PT_W-1]}}, current_x};
            p0y   <= {{(PW-PT_W){current_y[PT_W-1]}}, current_y};
            qx    <= {ex_in[PW-1], ex_in};
            qy    <= {ey_in[PW-1], ey_in};
            n     <= n_in;
            k     <= SW'(1);
            ustep <= '0;
            if ((bof_pkg::op_t'(op) == bof_pkg::OP_MOVE) ||
                (bof_pkg::op_t'(op) == bof_pkg::OP_LINE)) begin
              state <= S_PUSH;
            end else begin
              state <= S_DEN;
            end
          end
        end
        S_DEN: begin
          den <= wres;
          if ((ustep == 3'd0) && is_cubic) begin
            ustep <= 3'd1;
          end else begin
            ustep <= '0;
            state <= S_WGT;
          end
        end
        S_WGT: begin
          if (is_cubic) begin
            case (ustep)
              3'd0:    t1 <= wres;
              3'd1:    w0 <= wres;
              3'd2:    t2 <= wres;
              3'd3:    w3 <= wres;
              3'd4:    u  <= wres;
              3'd5:    w1 <= wres;
              3'd6:    u  <= wres;
              default: w2 <= wres;
            endcase
            if (ustep == 3'd7) begin
              ustep <= '0;
              state <= S_MACX;
            end else begin
              ustep <= ustep + 3'd1;
            end
          end else begin
            case (ustep)
              3'd0:    w0 <= wres;
              3'd1:    w3 <= wres;
              3'd2:    u  <= wres;
              default: begin
                w1 <= wres;
                w2 <= '0;
              end
            endcase
            if (ustep == 3'd3) begin
              ustep <= '0;
              state <= S_MACX;
            end else begin
              ustep <= ustep + 3'd1;
            end
          end
        end
        S_MACX: begin
          acc <= mac_res;
          if (ustep == 3'd3) begin
            ustep <= '0;
            state <= S_DIVX;
          end else begin
            ustep <= ustep + 3'd1;
          end
        end
        S_DIVX: begin
          if (div_stat.done) begin
            qx    <= div_quot;
            state <= S_MACY;
          end
        end
        S_MACY: begin
          acc <= mac_res;
          if (ustep == 3'd3) begin
            ustep <= '0;
            state <= S_DIVY;
          end else begin
            ustep <= ustep + 3'd1;
          end
        end
        S_DIVY: begin
          if (div_stat.done) begin
            qy    <= div_quot;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            point_x        <= sat_x;
            point_y        <= sat_y;
            starts_contour <= (op_q == bof_pkg::OP_MOVE);
            last           <= pt_last;
            current_x      <= sat_x;
            current_y      <= sat_y;
            if (pt_last) begin
              state <= S_IDLE;
            end else begin
              k     <= k + SW'(1);
              ustep <= '0;
              state <= S_WGT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // One request at a time: the block is busy right after taking one.
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while the previous one is still in work");

  // The divider is never restarted while it is still working.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A move gives exactly one point.
  a_move_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && starts_contour) |-> last)
    else $error("contour start point not marked as last");

  // The curve index stays within one to the step count.
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WGT) |-> ((k != '0) && (k <= n)))
    else $error("curve index out of range");
`endif

endmodule

### bench/bezier_outline_flattener_top_tb.sv
// Self-checking testbench for the Bezier outline flattener with random handshake stalls.
`timescale 1ns / 1ps

module bezier_outline_flattener_top_tb;

  localparam int ADDR_W   = bof_pkg::ADDR_W;
  localparam int DATA_W   = bof_pkg::DATA_W;
  localparam int COORD_W  = bof_pkg::COORD_W;
  localparam int OFFSET_W = bof_pkg::OFFSET_W;
  localparam int POINT_W  = bof_pkg::POINT_W;
  localparam int STEPS_W  = bof_pkg::STEPS_W;

  localparam int MAX_POINTS = 64;
  localparam int FRAC = 8;
  localparam logic [ADDR_W-1:0] STEPS_ADDR = ADDR_W'(4 * bof_pkg::REG_STEPS);

  // One outline command request, as driven on the command channel.
  typedef struct {
    bof_pkg::op_t               op;
    logic signed [COORD_W-1:0]  ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y;
    logic signed [OFFSET_W-1:0] offset_x, offset_y;
  } outline_cmd_t;

  // One point expected on the point channel.
  typedef struct {
    logic signed [POINT_W-1:0] x, y;
    logic                      starts, fin;
  } outline_point_t;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = 2'd0;
  logic signed [COORD_W-1:0] ctrl1_x = '0, ctrl1_y = '0, ctrl2_x = '0, ctrl2_y = '0;
  logic signed [COORD_W-1:0] end_x = '0, end_y = '0;
  logic signed [OFFSET_W-1:0] offset_x = '0, offset_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [POINT_W-1:0] point_x, point_y;
  logic starts_contour, last;

  // Predictor state: pen position and the steps register as last written.
  longint pen_x, pen_y;
  logic [STEPS_W-1:0] steps_setting;
  outline_point_t expected_points[$];

  int error_count = 0;
  int cmds_sent = 0;
  int curves_sent = 0;
  int points_checked = 0;
  int settings_used = 0;
  bit quiet = 1'b0;
  int ready_hold = 0;

  bezier_outline_flattener_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .ctrl1_x(ctrl1_x), .ctrl1_y(ctrl1_y), .ctrl2_x(ctrl2_x), .ctrl2_y(ctrl2_y),
    .end_x(end_x), .end_y(end_y), .offset_x(offset_x), .offset_y(offset_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .point_x(point_x), .point_y(point_y), .starts_contour(starts_contour), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("bezier_outline_flattener_top verification failed");
    $finish;
  end

  // Reports one mismatch; printing is capped, counting is not.
  task automatic flag_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Font units to Q.8 with the glyph offset added, held wide.
  function automatic longint to_q8(input logic signed [COORD_W-1:0] units,
                                   input logic signed [OFFSET_W-1:0] off);
    return longint'(units) * (longint'(1) << FRAC) + longint'(off);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
    if (v < -longint'(64'sd2147483648)) return -longint'(64'sd2147483648);
    return v;
  endfunction

  // Round to nearest, ties away from zero.
  function automatic longint round_div(input longint num, input longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  // Saturates a point, moves the pen there and queues it.
  function automatic void log_point(input longint x, input longint y,
                                    input logic starts, input logic fin);
    outline_point_t p;
    pen_x = clamp32(x);
    pen_y = clamp32(y);
    p.x = POINT_W'(pen_x);
    p.y = POINT_W'(pen_y);
    p.starts = starts;
    p.fin = fin;
    expected_points = {expected_points, p};
  endfunction

  // Works out every point that one command produces.
  function automatic void flatten_command(input outline_cmd_t c);
    longint ex, ey, c1x, c1y, c2x, c2y, p0x, p0y, n, m, den, nx, ny;
    ex = to_q8(c.end_x, c.offset_x);
    ey = to_q8(c.end_y, c.offset_y);
    if (c.op == bof_pkg::OP_MOVE || c.op == bof_pkg::OP_LINE) begin
      log_point(ex, ey, c.op == bof_pkg::OP_MOVE, 1'b1);
    end else begin
      c1x = to_q8(c.ctrl1_x, c.offset_x);
      c1y = to_q8(c.ctrl1_y, c.offset_y);
      c2x = to_q8(c.ctrl2_x, c.offset_x);
      c2y = to_q8(c.ctrl2_y, c.offset_y);
      p0x = pen_x;
      p0y = pen_y;
      n = longint'(steps_setting);
      if (n < 1) n = 1;
      if (n > MAX_POINTS) n = MAX_POINTS;
      for (longint k = 1; k <= n; k++) begin
        m = n - k;
        if (c.op == bof_pkg::OP_QUAD) begin
          den = n * n;
          nx = m * m * p0x + 2 * k * m * c1x + k * k * ex;
          ny = m * m * p0y + 2 * k * m * c1y + k * k * ey;
        end else begin
          den = n * n * n;
          nx = m * m * m * p0x + 3 * k * m * m * c1x + 3 * k * k * m * c2x + k * k * k * ex;
          ny = m * m * m * p0y + 3 * k * m * m * c1y + 3 * k * k * m * c2y + k * k * k * ey;
        end
        log_point(round_div(nx, den), round_div(ny, den), 1'b0, k == n);
      end
    end
  endfunction

  function automatic outline_cmd_t make_cmd(input bof_pkg::op_t o, input int c1x,
                                            input int c1y, input int c2x, input int c2y,
                                            input int ex, input int ey, input int ox,
                                            input int oy);
    outline_cmd_t c;
    c.op = o;
    c.ctrl1_x = COORD_W'(c1x);
    c.ctrl1_y = COORD_W'(c1y);
    c.ctrl2_x = COORD_W'(c2x);
    c.ctrl2_y = COORD_W'(c2y);
    c.end_x = COORD_W'(ex);
    c.end_y = COORD_W'(ey);
    c.offset_x = ox;
    c.offset_y = oy;
    return c;
  endfunction

  // Coordinates: mostly modest, some full range, some at the extremes.
  function automatic int pick_coord();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return int'($urandom_range(0, 4000)) - 2000;
    if (roll < 80) return int'(COORD_W'($urandom));
    case ($urandom_range(0, 3))
      0: return 8388607;
      1: return -8388608;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic int pick_offset();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return int'($urandom_range(0, 131072)) - 65536;
    if (roll < 80) return int'($urandom);
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic outline_cmd_t random_cmd(input bof_pkg::op_t o, input int ox,
                                              input int oy);
    return make_cmd(o, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    pick_coord(), pick_coord(), ox, oy);
  endfunction

  // Sender idle time: often none, mostly short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drives one command request and predicts its points once it is taken.
  task automatic send_command(input outline_cmd_t c);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op <= c.op;
    ctrl1_x <= c.ctrl1_x;
    ctrl1_y <= c.ctrl1_y;
    ctrl2_x <= c.ctrl2_x;
    ctrl2_y <= c.ctrl2_y;
    end_x <= c.end_x;
    end_y <= c.end_y;
    offset_x <= c.offset_x;
    offset_y <= c.offset_y;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    flatten_command(c);
    cmds_sent++;
    if (c.op == bof_pkg::OP_QUAD || c.op == bof_pkg::OP_CUBIC) curves_sent++;
  endtask

  // Stops sending and waits for every predicted point to come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  // Writes the steps register while idle, then reads it back.
  task automatic program_steps(input logic [STEPS_W-1:0] val);
    logic [DATA_W-1:0] word;
    settle();
    word = $urandom;
    word[STEPS_W-1:0] = val;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= STEPS_ADDR;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    steps_setting = val;
    settings_used++;
    // Read back with psel held high into the next setup phase.
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[STEPS_W-1:0] !== val)
      flag_mismatch($sformatf("steps readback got %0d want %0d", prdata[STEPS_W-1:0], val));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver stalls: long ready stretches, short stalls, occasional long ones.
  always @(posedge clk) begin
    int roll;
    if (quiet) begin
      out_ready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(0, 30);
      end else if (roll < 95) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(20, 60);
      end
    end
  end

  // Compares each accepted point with the oldest prediction.
  always @(posedge clk) begin
    outline_point_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        flag_mismatch($sformatf("unexpected point (%0d, %0d)", point_x, point_y));
      end else begin
        want = expected_points.pop_front();
        if (point_x !== want.x || point_y !== want.y ||
            starts_contour !== want.starts || last !== want.fin)
          flag_mismatch($sformatf("point %0d: got (%0d, %0d, s%b, l%b) want (%0d, %0d, s%b, l%b)",
                                  points_checked, point_x, point_y, starts_contour, last,
                                  want.x, want.y, want.starts, want.fin));
      end
      points_checked++;
    end
  end

  // A curve and a line straight after reset start from the origin with steps at one.
  task automatic test_curve_from_reset();
    send_command(make_cmd(bof_pkg::OP_QUAD, 1000, -1000, 5, 5, 2000, 300, 128, -128));
    send_command(make_cmd(bof_pkg::OP_LINE, 0, 0, 0, 0, -77, 91, 0, 0));
  endtask

  // Points past the 32-bit range clamp, and the clamped point becomes the pen.
  task automatic test_saturation();
    send_command(make_cmd(bof_pkg::OP_MOVE, 0, 0, 0, 0, 8388607, 8388607,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_command(make_cmd(bof_pkg::OP_MOVE, 0, 0, 0, 0, -8388608, -8388608,
                          32'h8000_0000, 32'h8000_0000));
    send_command(make_cmd(bof_pkg::OP_LINE, 0, 0, 0, 0, 8388607, -8388608,
                          32'h8000_0000, 32'h7FFF_FFFF));
    send_command(make_cmd(bof_pkg::OP_CUBIC, -8388608, 8388607, 8388607, -8388608,
                          8388607, 8388607, 32'h7FFF_FFFF, -1));
  endtask

  // Half-way values round away from zero on both signs.
  task automatic test_rounding_ties();
    program_steps(7'd2);
    send_command(make_cmd(bof_pkg::OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_cmd(bof_pkg::OP_QUAD, 0, 0, 0, 0, 0, 0, 2, -2));
    send_command(make_cmd(bof_pkg::OP_CUBIC, 0, 0, 0, 0, 0, 0, 6, -6));
  endtask

  // Steps of zero act as one; steps above the maximum clamp to it.
  task automatic test_step_limits();
    program_steps(7'd0);
    send_command(random_cmd(bof_pkg::OP_QUAD, pick_offset(), pick_offset()));
    send_command(random_cmd(bof_pkg::OP_CUBIC, pick_offset(), pick_offset()));
    program_steps(7'd127);
    send_command(make_cmd(bof_pkg::OP_CUBIC, 8388607, -8388608, -8388608, 8388607,
                          8388607, -8388608, 32'h7FFF_FFFF, 32'h8000_0000));
    send_command(make_cmd(bof_pkg::OP_QUAD, -8388608, 8388607, 0, 0, 8388607, 8388607,
                          32'h8000_0000, 32'h7FFF_FFFF));
    program_steps(7'(MAX_POINTS));
    send_command(random_cmd(bof_pkg::OP_CUBIC, pick_offset(), pick_offset()));
  endtask

  // Control fields that the operation does not use must not matter.
  task automatic test_ignored_controls();
    program_steps(7'd3);
    send_command(random_cmd(bof_pkg::OP_MOVE, 4096, -4096));
    send_command(random_cmd(bof_pkg::OP_LINE, 4096, -4096));
    send_command(random_cmd(bof_pkg::OP_QUAD, 4096, -4096));
    send_command(random_cmd(bof_pkg::OP_CUBIC, 4096, -4096));
  endtask

  // Random glyph outlines: a move, then a handful of segments sharing an offset.
  task automatic test_random_outlines();
    int ox, oy, count, roll;
    bof_pkg::op_t o;
    for (int phase = 0; phase < 5; phase++) begin
      program_steps(phase == 3 ? 7'($urandom_range(9, 16)) : 7'($urandom_range(1, 8)));
      quiet = (phase == 4);
      count = 0;
      while (count < 30) begin
        ox = pick_offset();
        oy = pick_offset();
        send_command(random_cmd(bof_pkg::OP_MOVE, ox, oy));
        count++;
        repeat ($urandom_range(2, 6)) begin
          roll = $urandom_range(0, 99);
          if (roll < 8) o = bof_pkg::OP_MOVE;
          else if (roll < 38) o = bof_pkg::OP_LINE;
          else if (roll < 69) o = bof_pkg::OP_QUAD;
          else o = bof_pkg::OP_CUBIC;
          // A stray offset change now and then breaks the glyph.
          if ($urandom_range(0, 9) == 0) begin
            ox = pick_offset();
            oy = pick_offset();
          end
          send_command(random_cmd(o, ox, oy));
          count++;
        end
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    pen_x = 0;
    pen_y = 0;
    steps_setting = bof_pkg::STEPS_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_curve_from_reset();
    test_saturation();
    test_rounding_ties();
    test_step_limits();
    test_ignored_controls();
    test_random_outlines();

    settle();
    repeat (200) @(posedge clk);
    $display("Sent %0d outline commands (%0d curves) under %0d steps settings.",
             cmds_sent, curves_sent, settings_used);
    $display("Checked %0d points; %0d mismatches.", points_checked, error_count);
    if (error_count == 0) begin
      $display("bezier_outline_flattener_top verification clean");
    end else begin
      $display("bezier_outline_flattener_top verification failed");
    end
    $finish;
  end

endmodule
